// File: rtl/core/dpb_pkg.sv
// Shared types and constants for the depth pixel back-projection block.
package dpb_pkg;

	localparam int COORD_W = 12;
	localparam int ADDR_W  = 5;
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
	localparam logic [2:0] REG_CENTER_X    = 3'd1;
	localparam logic [2:0] REG_CENTER_Y    = 3'd2;
	localparam logic [2:0] REG_INV_FOCAL_X = 3'd3;
	localparam logic [2:0] REG_INV_FOCAL_Y = 3'd4;
	localparam logic [2:0] REG_DEPTH_GAIN  = 3'd5;

	localparam logic [12:0] RST_IMAGE_WIDTH = 13'd1280;
	localparam logic [15:0] RST_CENTER_X    = 16'd10128;
	localparam logic [15:0] RST_CENTER_Y    = 16'd6464;
	localparam logic [23:0] RST_INV_FOCAL_X = 24'd24600;
	localparam logic [23:0] RST_INV_FOCAL_Y = 24'd24600;
	localparam logic [31:0] RST_DEPTH_GAIN  = 32'd4294967;

	typedef struct packed {
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [23:0] inv_focal_x;
		logic [23:0] inv_focal_y;
		logic [31:0] depth_gain;
	} cam_cfg_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [30:0]        pos_z;
	} point_t;

endpackage

// File: rtl/core/dpb_mul.sv
// Shared unsigned multiplier with a registered product.
module dpb_mul import dpb_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] prod
);

	logic [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

	assign prod = prod_q;

endmodule

// File: rtl/core/dpb_core.sv
// Sequencer that computes z, x and y of one pixel on the shared multiplier.
module dpb_core import dpb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        raw_depth,
	input  logic [COORD_W-1:0] col,
	input  logic [COORD_W-1:0] row,
	input  cam_cfg_t           cfg,
	input  logic               slot_free,
	output logic               busy,
	output logic               done,
	output point_t             point
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ZQ    = 3'd1;
	localparam logic [2:0] ST_MUL_M = 3'd2;
	localparam logic [2:0] ST_SPLIT = 3'd3;
	localparam logic [2:0] ST_HI    = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]         state_q;
	logic               axis_q;
	logic [31:0]        zq_q;
	logic [15:0]        mag_x_q, mag_y_q;
	logic               neg_x_q, neg_y_q;
	logic [23:0]        mhi_q;
	logic [47:0]        acc_q;
	logic [31:0]        pos_x_q;

	logic               mul_en;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;

	logic signed [16:0] dx, dy;
	logic [16:0]        adx, ady;
	logic [23:0]        inv_sel;
	logic [48:0]        z_sum;
	logic [72:0]        total;
	logic [44:0]        q;
	logic               neg_sel;
	logic [31:0]        sat_val;

	dpb_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// signed Q12.4 offsets from the principal point
	assign dx  = $signed({1'b0, col, 4'b0}) - $signed({1'b0, cfg.center_x});
	assign dy  = $signed({1'b0, row, 4'b0}) - $signed({1'b0, cfg.center_y});
	assign adx = dx[16] ? 17'(-dx) : 17'(dx);
	assign ady = dy[16] ? 17'(-dy) : 17'(dy);

	assign inv_sel = axis_q ? cfg.inv_focal_y : cfg.inv_focal_x;
	assign neg_sel = axis_q ? neg_y_q : neg_x_q;
	assign z_sum   = {1'b0, prod[47:0]} + 49'h0_0000_0000_8000;

	// low partial plus high partial shifted, rounded at bit 27
	assign total = {25'b0, acc_q} + {1'b0, prod[47:0], 24'b0} + {45'b0, 1'b1, 27'b0};
	assign q     = total[72:28];

	always_comb begin
		if (neg_sel) begin
			sat_val = (q[44:31] != 14'b0) ? 32'h8000_0000 : 32'b0 - q[31:0];
		end else begin
			sat_val = (q[44:31] != 14'b0) ? 32'h7FFF_FFFF : q[31:0];
		end
	end

	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					mul_en = 1'b1;
					mul_a  = cfg.depth_gain;
					mul_b  = {8'b0, raw_depth};
				end
			end
			ST_MUL_M: begin
				mul_en = 1'b1;
				mul_a  = zq_q;
				mul_b  = {8'b0, axis_q ? mag_y_q : mag_x_q};
			end
			ST_SPLIT: begin
				mul_en = 1'b1;
				mul_a  = {8'b0, inv_sel};
				mul_b  = prod[23:0];
			end
			ST_HI: begin
				mul_en = 1'b1;
				mul_a  = {8'b0, inv_sel};
				mul_b  = mhi_q;
			end
			ST_FIN: begin
				// x done: start the y offset product straight away
				if (!axis_q) begin
					mul_en = 1'b1;
					mul_a  = zq_q;
					mul_b  = {8'b0, mag_y_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_ZQ;
					end
				end
				ST_ZQ: begin
					axis_q  <= 1'b0;
					state_q <= ST_MUL_M;
				end
				ST_MUL_M: state_q <= ST_SPLIT;
				ST_SPLIT: state_q <= ST_HI;
				ST_HI:    state_q <= ST_FIN;
				ST_FIN: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= ST_SPLIT;
					end else if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			mag_x_q <= adx[15:0];
			mag_y_q <= ady[15:0];
			neg_x_q <= dx[16];
			neg_y_q <= dy[16];
		end
		if (state_q == ST_ZQ) begin
			zq_q <= z_sum[47:16];
		end
		if (state_q == ST_SPLIT) begin
			mhi_q <= prod[47:24];
		end
		if (state_q == ST_HI) begin
			acc_q <= prod[47:0];
		end
		if (state_q == ST_FIN && !axis_q) begin
			pos_x_q <= sat_val;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = (state_q == ST_FIN) && axis_q && slot_free;
	assign point.pos_x = pos_x_q;
	assign point.pos_y = sat_val;
	assign point.pos_z = zq_q[31] ? 31'h7FFF_FFFF : zq_q[30:0];

endmodule

// File: rtl/core/depth_pixel_backprojection.sv
// Top level: register port, raster counters, sequencer and output register.
//
//  channel  direction  handshake          payload
//  in       sink       in_valid/in_stall  raw_depth, blue, green, red, frame_start
//  out      source     out_valid/out_stall pos_x, pos_y, pos_z, out_red/green/blue
//  apb      sink       psel/penable/pready register writes and reads
//
// A pixel with non-zero depth keeps the sequencer busy while one 32x24
// multiplier is issued seven times (z, then per axis the offset product and
// two reciprocal partials). A zero-depth pixel does not start the sequencer.
// Reset clears the sequencer, the counters and the output valid.
// A held output stalls the sequencer in its last step; input stalls meanwhile.
module depth_pixel_backprojection import dpb_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        raw_depth,
	input  logic [7:0]         blue,
	input  logic [7:0]         green,
	input  logic [7:0]         red,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [30:0]        pos_z,
	output logic [7:0]         out_red,
	output logic [7:0]         out_green,
	output logic [7:0]         out_blue,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam logic [CW:0] MaxW = (CW+1)'(MAX_WIDTH);
	localparam logic [RW:0] MaxH = (RW+1)'(MAX_HEIGHT);

	logic [12:0]   img_width_q;
	cam_cfg_t      cfg_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [7:0]    red_q, green_q, blue_q;
	logic          out_valid_q;
	point_t        out_pt_q;
	logic [7:0]    out_red_q, out_green_q, out_blue_q;

	logic          in_accept, cfg_wr, core_start, core_busy, core_done, slot_free;
	logic [CW-1:0] col_used;
	logic [RW-1:0] row_used;
	logic [CW:0]   col_next;
	logic [RW:0]   row_next;
	logic          col_wrap, row_wrap;
	point_t        core_pt;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign in_stall  = core_busy;
	assign in_accept = in_valid && !in_stall;
	assign core_start = in_accept && (raw_depth != 16'b0);
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q       <= RST_IMAGE_WIDTH;
			cfg_q.center_x    <= RST_CENTER_X;
			cfg_q.center_y    <= RST_CENTER_Y;
			cfg_q.inv_focal_x <= RST_INV_FOCAL_X;
			cfg_q.inv_focal_y <= RST_INV_FOCAL_Y;
			cfg_q.depth_gain  <= RST_DEPTH_GAIN;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_IMAGE_WIDTH: img_width_q       <= pwdata[12:0];
				REG_CENTER_X:    cfg_q.center_x    <= pwdata[15:0];
				REG_CENTER_Y:    cfg_q.center_y    <= pwdata[15:0];
				REG_INV_FOCAL_X: cfg_q.inv_focal_x <= pwdata[23:0];
				REG_INV_FOCAL_Y: cfg_q.inv_focal_y <= pwdata[23:0];
				REG_DEPTH_GAIN:  cfg_q.depth_gain  <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_IMAGE_WIDTH: prdata = 32'(img_width_q);
			REG_CENTER_X:    prdata = 32'(cfg_q.center_x);
			REG_CENTER_Y:    prdata = 32'(cfg_q.center_y);
			REG_INV_FOCAL_X: prdata = 32'(cfg_q.inv_focal_x);
			REG_INV_FOCAL_Y: prdata = 32'(cfg_q.inv_focal_y);
			REG_DEPTH_GAIN:  prdata = cfg_q.depth_gain;
			default:         prdata = 32'b0;
		endcase
	end

	// raster position; frame start clears it for this pixel
	assign col_used = frame_start ? '0 : col_q;
	assign row_used = frame_start ? '0 : row_q;
	assign col_next = {1'b0, col_used} + (CW+1)'(1);
	assign row_next = {1'b0, row_used} + (RW+1)'(1);
	assign col_wrap = (13'(col_next) >= img_width_q) || (col_next >= MaxW);
	assign row_wrap = (row_next >= MaxH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_next[RW-1:0];
			end else begin
				col_q <= col_next[CW-1:0];
				row_q <= row_used;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
		end
	end

	dpb_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (core_start),
		.raw_depth (raw_depth),
		.col       (COORD_W'(col_used)),
		.row       (COORD_W'(row_used)),
		.cfg       (cfg_q),
		.slot_free (slot_free),
		.busy      (core_busy),
		.done      (core_done),
		.point     (core_pt)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) begin
			out_pt_q    <= core_pt;
			out_red_q   <= red_q;
			out_green_q <= green_q;
			out_blue_q  <= blue_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = out_pt_q.pos_x;
	assign pos_y     = out_pt_q.pos_y;
	assign pos_z     = out_pt_q.pos_z;
	assign out_red   = out_red_q;
	assign out_green = out_green_q;
	assign out_blue  = out_blue_q;

`ifndef SYNTHESIS
	a_done_slot: assert property (@(posedge clk) disable iff (!arst_n)
		core_done |-> (!out_valid_q || !out_stall))
		else $error("result finished into an occupied output word");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		core_start |=> core_busy)
		else $error("sequencer did not leave idle after a start");

	a_zero_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && raw_depth == 16'b0) |=> !core_busy)
		else $error("zero-depth word started the sequencer");

	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		core_done |=> out_valid)
		else $error("finished result not presented");
`endif

endmodule
